>>> hdl/tgow_pkg.sv
// Shared types, constants and glyph font for the text glyph overlay writer.
`default_nettype none
package tgow_pkg;

  localparam int GlyphRows       = 9;
  localparam int GlyphCols       = 7;
  localparam int LastGlyphOnLine = 8;
  localparam int LinePitch       = 10;
  localparam int BlankGlyph      = 39;
  localparam int NoGlyph         = 40;
  localparam int FrameRowsDef    = 128;
  localparam int FrameColsDef    = 128;

  localparam logic [6:0] StartRowRst = 7'd0;
  localparam logic [6:0] StartColRst = 7'd7;
  localparam logic [6:0] WrapColRst  = 7'd7;
  localparam logic [7:0] InkRst      = 8'd200;

  typedef enum logic [1:0] {
    ACT_DRAW = 2'd0,
    ACT_GAP  = 2'd1,
    ACT_HOME = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_START_ROW = 2'd0,
    CFG_START_COL = 2'd1,
    CFG_WRAP_COL  = 2'd2,
    CFG_INK_VALUE = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [5:0] glyph;
    logic [7:0] row;
    logic [7:0] col;
    logic [3:0] nrows;
    logic [2:0] ncols;
  } cmd_t;

  typedef logic [0:8][6:0] glyph_t;

  function automatic logic [5:0] glyph_index(input logic [7:0] code);
    logic [5:0] idx;
    idx = 6'(NoGlyph);
    if (code >= 8'd97 && code <= 8'd122) idx = 6'(code - 8'd97);
    else if (code >= 8'd48 && code <= 8'd57) idx = 6'(code - 8'd22);
    else if (code == 8'd46) idx = 6'd36;
    else if (code == 8'd44) idx = 6'd37;
    else if (code == 8'd33) idx = 6'd38;
    return idx;
  endfunction

  function automatic glyph_t glyph_font(input logic [5:0] idx);
    glyph_t g;
    case (idx)
      6'd0:  g = {7'd0, 7'd8, 7'd20, 7'd34, 7'd62, 7'd34, 7'd34, 7'd34, 7'd0};
      6'd1:  g = {7'd0, 7'd60, 7'd34, 7'd34, 7'd60, 7'd34, 7'd34, 7'd60, 7'd0};
      6'd2:  g = {7'd0, 7'd28, 7'd34, 7'd32, 7'd32, 7'd32, 7'd34, 7'd28, 7'd0};
      6'd3:  g = {7'd0, 7'd60, 7'd34, 7'd34, 7'd34, 7'd34, 7'd34, 7'd60, 7'd0};
      6'd4:  g = {7'd0, 7'd62, 7'd32, 7'd32, 7'd60, 7'd32, 7'd32, 7'd62, 7'd0};
      6'd5:  g = {7'd0, 7'd62, 7'd32, 7'd32, 7'd60, 7'd32, 7'd32, 7'd32, 7'd0};
      6'd6:  g = {7'd0, 7'd28, 7'd34, 7'd32, 7'd38, 7'd34, 7'd34, 7'd30, 7'd0};
      6'd7:  g = {7'd0, 7'd34, 7'd34, 7'd34, 7'd62, 7'd34, 7'd34, 7'd34, 7'd0};
      6'd8:  g = {7'd0, 7'd62, 7'd8, 7'd8, 7'd8, 7'd8, 7'd8, 7'd62, 7'd0};
      6'd9:  g = {7'd0, 7'd62, 7'd8, 7'd8, 7'd8, 7'd40, 7'd40, 7'd16, 7'd0};
      6'd10: g = {7'd0, 7'd34, 7'd36, 7'd40, 7'd48, 7'd40, 7'd36, 7'd34, 7'd0};
      6'd11: g = {7'd0, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd62, 7'd0};
      6'd12: g = {7'd0, 7'd34, 7'd54, 7'd42, 7'd42, 7'd42, 7'd42, 7'd42, 7'd0};
      6'd13: g = {7'd0, 7'd34, 7'd50, 7'd42, 7'd42, 7'd38, 7'd38, 7'd34, 7'd0};
      6'd14: g = {7'd0, 7'd28, 7'd34, 7'd34, 7'd34, 7'd34, 7'd34, 7'd28, 7'd0};
      6'd15: g = {7'd0, 7'd60, 7'd34, 7'd34, 7'd60, 7'd32, 7'd32, 7'd32, 7'd0};
      6'd16: g = {7'd0, 7'd28, 7'd34, 7'd34, 7'd34, 7'd42, 7'd38, 7'd30, 7'd0};
      6'd17: g = {7'd0, 7'd60, 7'd34, 7'd34, 7'd60, 7'd34, 7'd34, 7'd34, 7'd0};
      6'd18: g = {7'd0, 7'd28, 7'd34, 7'd32, 7'd28, 7'd2, 7'd34, 7'd28, 7'd0};
      6'd19: g = {7'd0, 7'd62, 7'd8, 7'd8, 7'd8, 7'd8, 7'd8, 7'd8, 7'd0};
      6'd20: g = {7'd0, 7'd34, 7'd34, 7'd34, 7'd34, 7'd34, 7'd34, 7'd28, 7'd0};
      6'd21: g = {7'd0, 7'd34, 7'd34, 7'd34, 7'd20, 7'd20, 7'd20, 7'd8, 7'd0};
      6'd22: g = {7'd0, 7'd34, 7'd42, 7'd42, 7'd42, 7'd28, 7'd28, 7'd20, 7'd0};
      6'd23: g = {7'd0, 7'd34, 7'd34, 7'd20, 7'd8, 7'd20, 7'd34, 7'd34, 7'd0};
      6'd24: g = {7'd0, 7'd34, 7'd34, 7'd20, 7'd8, 7'd8, 7'd8, 7'd8, 7'd0};
      6'd25: g = {7'd0, 7'd62, 7'd2, 7'd4, 7'd8, 7'd16, 7'd32, 7'd62, 7'd0};
      6'd26: g = {7'd0, 7'd28, 7'd38, 7'd38, 7'd42, 7'd42, 7'd50, 7'd28, 7'd0};
      6'd27: g = {7'd0, 7'd8, 7'd24, 7'd40, 7'd8, 7'd8, 7'd8, 7'd62, 7'd0};
      6'd28: g = {7'd0, 7'd28, 7'd34, 7'd4, 7'd8, 7'd16, 7'd32, 7'd62, 7'd0};
      6'd29: g = {7'd0, 7'd28, 7'd34, 7'd2, 7'd28, 7'd2, 7'd34, 7'd28, 7'd0};
      6'd30: g = {7'd0, 7'd40, 7'd40, 7'd40, 7'd62, 7'd8, 7'd8, 7'd8, 7'd0};
      6'd31: g = {7'd0, 7'd62, 7'd32, 7'd32, 7'd60, 7'd2, 7'd34, 7'd28, 7'd0};
      6'd32: g = {7'd0, 7'd28, 7'd34, 7'd32, 7'd60, 7'd34, 7'd34, 7'd28, 7'd0};
      6'd33: g = {7'd0, 7'd62, 7'd2, 7'd2, 7'd4, 7'd8, 7'd16, 7'd32, 7'd0};
      6'd34: g = {7'd0, 7'd28, 7'd34, 7'd34, 7'd28, 7'd34, 7'd34, 7'd28, 7'd0};
      6'd35: g = {7'd0, 7'd28, 7'd34, 7'd34, 7'd30, 7'd2, 7'd2, 7'd2, 7'd0};
      6'd36: g = {7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd24, 7'd24, 7'd0};
      6'd37: g = {7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd24, 7'd24, 7'd8};
      6'd38: g = {7'd0, 7'd8, 7'd8, 7'd8, 7'd8, 7'd8, 7'd0, 7'd8, 7'd0};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

>>> hdl/tgow_front.sv
// Front end: accepts characters, tracks the text cursor, issues glyph commands.
`default_nettype none
module tgow_front #(
  parameter int FRAME_ROWS = tgow_pkg::FrameRowsDef,
  parameter int FRAME_COLS = tgow_pkg::FrameColsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [1:0]       action_i,
  input  wire logic [7:0]       char_code_i,
  input  wire logic [6:0]       start_row_i,
  input  wire logic [6:0]       start_col_i,
  input  wire logic [6:0]       wrap_col_i,
  output tgow_pkg::cmd_t        cmd_o,
  output logic                  push_o
);
  import tgow_pkg::*;

  localparam int RowW = ($clog2(FRAME_ROWS + 1) > 9) ? $clog2(FRAME_ROWS + 1) : 9;
  localparam int ColW = ($clog2(FRAME_COLS + 1) > 9) ? $clog2(FRAME_COLS + 1) : 9;

  logic [7:0] row_q, row_d, col_q, col_d;
  logic [3:0] line_q, line_d;
  action_e    act;
  logic [5:0] glyph;
  logic [8:0] row_sum, col_sum;
  logic [7:0] col_adv, row_adv;
  logic [RowW-1:0] row_ext, row_room;
  logic [ColW-1:0] col_ext, col_room;
  logic [3:0] nrows;
  logic [2:0] ncols;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= {1'b0, StartRowRst};
      col_q  <= {1'b0, StartColRst};
      line_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      line_q <= line_d;
    end
  end

  always_comb begin
    act      = action_e'(action_i);
    glyph    = (act == ACT_GAP) ? 6'(BlankGlyph) : glyph_index(char_code_i);
    row_ext  = RowW'(row_q);
    col_ext  = ColW'(col_q);
    row_room = RowW'(FRAME_ROWS) - row_ext;
    col_room = ColW'(FRAME_COLS) - col_ext;
    if (row_ext >= RowW'(FRAME_ROWS)) nrows = '0;
    else if (row_room >= RowW'(GlyphRows)) nrows = 4'(GlyphRows);
    else nrows = 4'(row_room);
    if (col_ext >= ColW'(FRAME_COLS)) ncols = '0;
    else if (col_room >= ColW'(GlyphCols)) ncols = 3'(GlyphCols);
    else ncols = 3'(col_room);
    col_sum = {1'b0, col_q} + 9'(GlyphCols);
    row_sum = {1'b0, row_q} + 9'(LinePitch);
    col_adv = col_sum[8] ? 8'hFF : col_sum[7:0];
    row_adv = row_sum[8] ? 8'hFF : row_sum[7:0];

    row_d  = row_q;
    col_d  = col_q;
    line_d = line_q;
    push_o = 1'b0;
    cmd_o  = '{glyph: glyph, row: row_q, col: col_q, nrows: nrows, ncols: ncols};

    if (accept_i) begin
      unique case (act) inside
        ACT_HOME: begin
          row_d  = {1'b0, start_row_i};
          col_d  = {1'b0, start_col_i};
          line_d = '0;
        end
        ACT_DRAW, ACT_GAP: begin
          push_o = (glyph != 6'(NoGlyph)) && (nrows != '0) && (ncols != '0);
          if (line_q >= 4'(LastGlyphOnLine)) begin
            col_d  = {1'b0, wrap_col_i};
            row_d  = row_adv;
            line_d = '0;
          end else begin
            col_d  = col_adv;
            line_d = line_q + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/tgow_queue.sv
// Two-entry command queue between the front end and the pixel walker.
`default_nettype none
module tgow_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tgow_pkg::cmd_t cmd_i,
  input  wire logic          pop_i,
  output tgow_pkg::cmd_t     cmd_o,
  output logic               valid_o,
  output logic               full_o
);
  import tgow_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= '0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

>>> hdl/tgow_back.sv
// Back end: walks each glyph cell by cell and registers one pixel write a cycle unless stalled.
`default_nettype none
module tgow_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tgow_pkg::cmd_t cmd_i,
  input  wire logic           cmd_valid_i,
  output logic                pop_o,
  output logic                busy_o,
  input  wire logic [7:0]     ink_value_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [6:0]          pixel_row_o,
  output logic [6:0]          pixel_col_o,
  output logic [7:0]          pixel_value_o,
  output logic                last_pixel_o
);
  import tgow_pkg::*;

  cmd_t       cur_q;
  logic       busy_q;
  logic [3:0] i_q;
  logic [2:0] j_q;
  logic       step, row_end, last_cell, dot;
  glyph_t     font;
  logic [6:0] bits;

  assign busy_o    = busy_q;
  assign step      = busy_q && (!out_valid_o || !out_stall_i);
  assign row_end   = (j_q == 3'(cur_q.ncols - 3'd1));
  assign last_cell = row_end && (i_q == 4'(cur_q.nrows - 4'd1));
  assign pop_o     = cmd_valid_i && (!busy_q || (step && last_cell));
  assign font      = glyph_font(cur_q.glyph);
  assign bits      = font[i_q];
  assign dot       = bits[3'(3'd6 - j_q)];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        i_q    <= '0;
        j_q    <= '0;
      end else if (step && last_cell) begin
        busy_q <= 1'b0;
      end else if (step) begin
        if (row_end) begin
          j_q <= '0;
          i_q <= i_q + 4'd1;
        end else begin
          j_q <= j_q + 3'd1;
        end
      end
      if (step) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= cmd_i;
    if (step) begin
      pixel_row_o   <= 7'(cur_q.row[6:0] + 7'(i_q));
      pixel_col_o   <= 7'(cur_q.col[6:0] + 7'(j_q));
      pixel_value_o <= dot ? ink_value_i : 8'd0;
      last_pixel_o  <= last_cell;
    end
  end

endmodule
`default_nettype wire

>>> hdl/text_glyph_overlay_writer_top.sv
// Top level of the text glyph overlay writer: config registers, front end, queue, back end.
//
// Usage: each input request carries action_i (draw, gap, home) and char_code_i.
// A draw of a-z, 0-9, period, comma or exclamation, and a gap, emit the in-frame
// cells of a 9x7 glyph at the cursor, row-major, one pixel write per cell on
// the output channel; last_pixel_o marks the final write of the character.
// Other codes, home, and fully off-frame glyphs emit nothing.
// A command passes a queue entry, the back end command register, then the pixel register.
// Throughput: one pixel per cycle while the output is not stalled; this is set
// by the back end walking one glyph cell per cycle. The front end runs ahead by
// up to two queued glyphs plus the one in progress, and takes one non-drawing
// item per cycle when the queue has room.
// Config: write registers 0..3 (start_row, start_col, wrap_col, ink_value) only
// while idle; cfg_ready_o is always high.
// Reset: cursor to row 0, column 7, registers to defaults, queue and output empty.
// Output stall holds the pixel register; the walk pauses and the queue fills,
// then in_stall_o rises.
`default_nettype none
module text_glyph_overlay_writer_top #(
  parameter int FRAME_ROWS = tgow_pkg::FrameRowsDef,
  parameter int FRAME_COLS = tgow_pkg::FrameColsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] action_i,
  input  wire logic [7:0] char_code_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [6:0]      pixel_row_o,
  output logic [6:0]      pixel_col_o,
  output logic [7:0]      pixel_value_o,
  output logic            last_pixel_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);
  import tgow_pkg::*;

  logic [6:0] start_row_q, start_col_q, wrap_col_q;
  logic [7:0] ink_q;
  logic       accept, push, q_full, q_valid, pop, back_busy;
  cmd_t       cmd_in, cmd_out;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_row_q <= StartRowRst;
      start_col_q <= StartColRst;
      wrap_col_q  <= WrapColRst;
      ink_q       <= InkRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_START_ROW: start_row_q <= cfg_data_i[6:0];
        CFG_START_COL: start_col_q <= cfg_data_i[6:0];
        CFG_WRAP_COL:  wrap_col_q  <= cfg_data_i[6:0];
        CFG_INK_VALUE: ink_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tgow_front #(
    .FRAME_ROWS(FRAME_ROWS),
    .FRAME_COLS(FRAME_COLS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .action_i   (action_i),
    .char_code_i(char_code_i),
    .start_row_i(start_row_q),
    .start_col_i(start_col_q),
    .wrap_col_i (wrap_col_q),
    .cmd_o      (cmd_in),
    .push_o     (push)
  );

  tgow_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .cmd_o  (cmd_out),
    .valid_o(q_valid),
    .full_o (q_full)
  );

  tgow_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_out),
    .cmd_valid_i  (q_valid),
    .pop_o        (pop),
    .busy_o       (back_busy),
    .ink_value_i  (ink_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_row_o  (pixel_row_o),
    .pixel_col_o  (pixel_col_o),
    .pixel_value_o(pixel_value_o),
    .last_pixel_o (last_pixel_o)
  );

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("command pushed into a full queue");

  a_idle_back_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !back_busy) |=> back_busy)
    else $error("queued command not taken by idle back end");

  a_pixel_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_value_o == 8'd0 || pixel_value_o == ink_q))
    else $error("pixel value is neither ink nor background");

endmodule
`default_nettype wire
